/* rtl/core/bas_pkg.sv */
package bas_pkg;

  // Grid geometry and field widths
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int LAYERS      = 4;
  localparam int TYPE_BITS   = 8;
  localparam int TABLE_SLOTS = 47;

  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int LAYER_BITS = $clog2(LAYERS);
  localparam int CELL_BITS  = LAYER_BITS + Y_BITS + X_BITS;
  localparam int CELLS      = LAYERS * MAX_HEIGHT * MAX_WIDTH;
  localparam int GRID_BITS  = 7;
  localparam int SLOT_BITS  = 6;
  localparam int VALUE_BITS = 32;
  localparam int NB_COUNT   = 8;
  localparam int STEP_BITS  = $clog2(NB_COUNT);

  // Operation codes carried in the input item
  typedef enum logic [1:0] {
    OP_WR_CELL = 2'd0,
    OP_WR_SLOT = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NB_TYPE = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_HEIGHT  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  // Neighbour bit positions, also the order in which neighbours are read
  localparam int NB_T  = 0;
  localparam int NB_R  = 1;
  localparam int NB_B  = 2;
  localparam int NB_L  = 3;
  localparam int NB_TL = 4;
  localparam int NB_TR = 5;
  localparam int NB_BR = 6;
  localparam int NB_BL = 7;

  localparam logic [7:0] M_T  = 8'h01;
  localparam logic [7:0] M_R  = 8'h02;
  localparam logic [7:0] M_B  = 8'h04;
  localparam logic [7:0] M_L  = 8'h08;
  localparam logic [7:0] M_TL = 8'h10;
  localparam logic [7:0] M_TR = 8'h20;
  localparam logic [7:0] M_BR = 8'h40;
  localparam logic [7:0] M_BL = 8'h80;

  // Canonical neighbour mask of each blob slot
  localparam logic [7:0] SLOT_MASK [TABLE_SLOTS] = '{
    M_R | M_BR | M_B,
    M_L | M_BL | M_B | M_BR | M_R,
    M_L | M_BL | M_B,
    M_T | M_TR | M_R | M_BR | M_B,
    M_T | M_R | M_B | M_L | M_TL | M_TR | M_BR | M_BL,
    M_T | M_TL | M_L | M_BL | M_B,
    M_T | M_TR | M_R,
    M_L | M_TL | M_T | M_TR | M_R,
    M_L | M_TL | M_T,
    M_R,
    M_L | M_R,
    M_L,
    M_B,
    M_T | M_B,
    M_T,
    8'h00,
    M_B | M_R,
    M_L | M_BL | M_B | M_R,
    M_L | M_B | M_BR | M_R,
    M_L | M_B,
    M_B | M_R | M_TR | M_T,
    M_L | M_BL | M_B | M_R | M_TR | M_T | M_TL,
    M_L | M_B | M_BR | M_R | M_TR | M_T | M_TL,
    M_T | M_TL | M_L | M_B,
    M_T | M_R | M_BR | M_B,
    M_T | M_R | M_BR | M_B | M_BL | M_L | M_TL,
    M_T | M_TR | M_R | M_BR | M_B | M_BL | M_L,
    M_T | M_B | M_BL | M_L,
    M_T | M_R,
    M_T | M_R | M_L | M_TL,
    M_T | M_TR | M_R | M_L,
    M_T | M_L,
    M_T | M_R | M_B,
    M_T | M_R | M_B | M_BL | M_L | M_TL,
    M_T | M_TR | M_R | M_BR | M_B | M_L,
    M_T | M_L | M_B,
    M_L | M_B | M_R,
    M_L | M_TL | M_T | M_TR | M_R | M_B,
    M_T | M_R | M_BR | M_B | M_BL | M_L,
    M_L | M_T | M_R,
    M_T | M_R | M_B | M_L,
    M_L | M_TL | M_T | M_R | M_BR | M_B,
    M_T | M_TR | M_R | M_B | M_BL | M_L,
    M_T | M_R | M_BR | M_B | M_L,
    M_T | M_TR | M_R | M_B | M_L,
    M_T | M_R | M_B | M_BL | M_L,
    M_T | M_R | M_B | M_L | M_TL
  };

  // Terrain side request: one write or the start of a query
  typedef struct packed {
    logic                  wr_en;
    logic                  qry_en;
    logic [LAYER_BITS-1:0] layer;
    logic [Y_BITS-1:0]     y;
    logic [X_BITS-1:0]     x;
    logic [TYPE_BITS-1:0]  wdata;
  } scan_req_t;

  // Grid settings after clamping
  typedef struct packed {
    logic [TYPE_BITS-1:0] nb_type;
    logic [GRID_BITS-1:0] width;
    logic [GRID_BITS-1:0] height;
  } grid_cfg_t;

  // Finished neighbour mask
  typedef struct packed {
    logic       valid;
    logic [7:0] mask;
  } mask_stat_t;

  // Tile table write
  typedef struct packed {
    logic                  en;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] data;
  } tbl_wr_t;

  // Looked-up result waiting for the output register
  typedef struct packed {
    logic                  valid;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] value;
  } tile_res_t;

  // Slot whose canonical mask equals m; the first match wins, slot 0 if none
  function automatic logic [SLOT_BITS-1:0] mask_to_slot(input logic [7:0] m);
    logic [SLOT_BITS-1:0] s;
    s = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (SLOT_MASK[i] == m) begin
        s = SLOT_BITS'(i);
      end
    end
    return s;
  endfunction

endpackage

/* rtl/core/bas_terrain.sv */
module bas_terrain
  import bas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scan_req_t  req,
  input  grid_cfg_t  cfg,
  output mask_stat_t stat
);

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_READ = 2'b10
  } scan_state_t;

  logic [TYPE_BITS-1:0] mem [CELLS];

  scan_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [LAYER_BITS-1:0] lay_r;
  logic [X_BITS-1:0]     x_r;
  logic [Y_BITS-1:0]     y_r;
  logic                  pend_r;
  logic [STEP_BITS-1:0]  pidx_r;
  logic                  pin_r;
  logic [7:0]            raw_r;
  logic                  done_r;
  logic [TYPE_BITS-1:0]  rdata_r;

  logic                  dx_neg, dx_pos, dy_neg, dy_pos;
  logic [GRID_BITS-1:0]  x_ext, y_ext, nx, ny;
  logic                  x_in, y_in;
  logic [CELL_BITS-1:0]  rd_addr, wr_addr;
  logic                  last_step;

  // Offset of the neighbour read in this step
  always_comb begin
    dx_neg = 1'b0;
    dx_pos = 1'b0;
    dy_neg = 1'b0;
    dy_pos = 1'b0;
    case (step_r)
      STEP_BITS'(NB_T):  dy_neg = 1'b1;
      STEP_BITS'(NB_R):  dx_pos = 1'b1;
      STEP_BITS'(NB_B):  dy_pos = 1'b1;
      STEP_BITS'(NB_L):  dx_neg = 1'b1;
      STEP_BITS'(NB_TL): begin
        dx_neg = 1'b1;
        dy_neg = 1'b1;
      end
      STEP_BITS'(NB_TR): begin
        dx_pos = 1'b1;
        dy_neg = 1'b1;
      end
      STEP_BITS'(NB_BR): begin
        dx_pos = 1'b1;
        dy_pos = 1'b1;
      end
      STEP_BITS'(NB_BL): begin
        dx_neg = 1'b1;
        dy_pos = 1'b1;
      end
      default: begin
        dx_neg = 1'b0;
      end
    endcase
  end

  // Neighbour coordinates and the check against the grid in use
  always_comb begin
    x_ext = GRID_BITS'(x_r);
    y_ext = GRID_BITS'(y_r);
    nx    = dx_neg ? x_ext - GRID_BITS'(1) : (dx_pos ? x_ext + GRID_BITS'(1) : x_ext);
    ny    = dy_neg ? y_ext - GRID_BITS'(1) : (dy_pos ? y_ext + GRID_BITS'(1) : y_ext);
    x_in  = !(dx_neg && (x_r == '0)) && (nx < cfg.width);
    y_in  = !(dy_neg && (y_r == '0)) && (ny < cfg.height);
  end

  assign rd_addr   = {lay_r, ny[Y_BITS-1:0], nx[X_BITS-1:0]};
  assign wr_addr   = {req.layer, req.y, req.x};
  assign last_step = (step_r == STEP_BITS'(NB_COUNT - 1));

  // Sequencer over the eight neighbours
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      SC_IDLE: begin
        if (req.qry_en) begin
          state_nxt = SC_READ;
          step_nxt  = '0;
        end
      end
      SC_READ: begin
        step_nxt = step_r + STEP_BITS'(1);
        if (last_step) begin
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      step_r  <= '0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pend_r  <= (state_r == SC_READ);
      done_r  <= pend_r && (pidx_r == STEP_BITS'(NB_COUNT - 1));
    end
  end

  // Query coordinates and per-step bookkeeping
  always_ff @(posedge clk) begin
    if (req.qry_en && (state_r == SC_IDLE)) begin
      lay_r <= req.layer;
      x_r   <= req.x;
      y_r   <= req.y;
    end
    pidx_r <= step_r;
    pin_r  <= x_in && y_in;
    if (pend_r) begin
      raw_r[pidx_r] <= pin_r && (rdata_r == cfg.nb_type);
    end
  end

  // Terrain memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wdata;
    end
    if (state_r == SC_READ) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // A diagonal counts only when both edges beside it match
  always_comb begin
    stat.valid       = done_r;
    stat.mask        = '0;
    stat.mask[NB_T]  = raw_r[NB_T];
    stat.mask[NB_R]  = raw_r[NB_R];
    stat.mask[NB_B]  = raw_r[NB_B];
    stat.mask[NB_L]  = raw_r[NB_L];
    stat.mask[NB_TL] = raw_r[NB_TL] && raw_r[NB_T] && raw_r[NB_L];
    stat.mask[NB_TR] = raw_r[NB_TR] && raw_r[NB_T] && raw_r[NB_R];
    stat.mask[NB_BR] = raw_r[NB_BR] && raw_r[NB_B] && raw_r[NB_R];
    stat.mask[NB_BL] = raw_r[NB_BL] && raw_r[NB_B] && raw_r[NB_L];
  end

endmodule

/* rtl/core/bas_tile.sv */
module bas_tile
  import bas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tbl_wr_t    wr,
  input  mask_stat_t mstat,
  input  logic       res_ready,
  output tile_res_t  res
);

  logic [VALUE_BITS-1:0] tbl [TABLE_SLOTS];

  logic [SLOT_BITS-1:0]  slot_c;
  logic [SLOT_BITS-1:0]  slot_r;
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  valid_r;

  assign slot_c = mask_to_slot(mstat.mask);

  // Tile table: writes to slots past the end are dropped
  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot < SLOT_BITS'(TABLE_SLOTS))) begin
      tbl[wr.slot] <= wr.data;
    end
    if (mstat.valid) begin
      rdata_r <= tbl[slot_c];
      slot_r  <= slot_c;
    end
  end

  // Result stays until the output register takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (mstat.valid) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign res.valid = valid_r;
  assign res.slot  = slot_r;
  assign res.value = rdata_r;

endmodule

/* rtl/core/blob_autotile_select.sv */
// Writes of a terrain cell or a tile slot do not make the block busy; in_tready stays high.
// A query reads its eight neighbours one per cycle from the terrain memory's read port,
// then one tile table word; in_tready stays low from the query transfer until the result
// is loaded into the output register, so no new item is taken while a query is in progress.
// Synchronous active-low reset clears control state and sets the grid to 64 by 64 and
// neighbour type 0; terrain and tile table contents are undefined until written.
module blob_autotile_select
  import bas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input item, from bit 0: operation[2], cell_x[6], cell_y[6], cell_layer[2],
  // table_slot[6], data_word[32], zero fill[2]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // Result item, from bit 0: tile_value[32], slot_index[6], zero_tile[1], zero fill[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [TYPE_BITS-1:0]  nb_type_r;
  logic [GRID_BITS-1:0]  width_r, height_r;
  logic                  busy_r;
  logic                  out_valid_r;
  logic [39:0]           out_data_r;

  logic                  in_fire, cfg_fire, load;
  op_t                   op;
  logic [X_BITS-1:0]     cell_x;
  logic [Y_BITS-1:0]     cell_y;
  logic [LAYER_BITS-1:0] cell_layer;
  logic [SLOT_BITS-1:0]  table_slot;
  logic [VALUE_BITS-1:0] data_word;

  scan_req_t  sreq;
  grid_cfg_t  gcfg;
  mask_stat_t mstat;
  tbl_wr_t    twr;
  tile_res_t  tres;

  // Unpack the input item
  assign op         = op_t'(in_tdata[1:0]);
  assign cell_x     = in_tdata[7:2];
  assign cell_y     = in_tdata[13:8];
  assign cell_layer = in_tdata[15:14];
  assign table_slot = in_tdata[21:16];
  assign data_word  = in_tdata[53:22];

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_type_r <= '0;
      width_r   <= GRID_BITS'(64);
      height_r  <= GRID_BITS'(64);
    end else if (cfg_fire) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NB_TYPE: nb_type_r <= cfg_data[TYPE_BITS-1:0];
        CFG_WIDTH:   width_r   <= cfg_data[GRID_BITS-1:0];
        CFG_HEIGHT:  height_r  <= cfg_data[GRID_BITS-1:0];
        default:     nb_type_r <= nb_type_r;
      endcase
    end
  end

  // Grid size of zero behaves as one; sizes beyond the store are capped
  always_comb begin
    gcfg.nb_type = nb_type_r;
    if (width_r == '0) begin
      gcfg.width = GRID_BITS'(1);
    end else if (width_r > GRID_BITS'(MAX_WIDTH)) begin
      gcfg.width = GRID_BITS'(MAX_WIDTH);
    end else begin
      gcfg.width = width_r;
    end
    if (height_r == '0) begin
      gcfg.height = GRID_BITS'(1);
    end else if (height_r > GRID_BITS'(MAX_HEIGHT)) begin
      gcfg.height = GRID_BITS'(MAX_HEIGHT);
    end else begin
      gcfg.height = height_r;
    end
  end

  // Route the accepted item
  always_comb begin
    sreq.wr_en  = in_fire && (op == OP_WR_CELL);
    sreq.qry_en = in_fire && (op == OP_QUERY);
    sreq.layer  = cell_layer;
    sreq.y      = cell_y;
    sreq.x      = cell_x;
    sreq.wdata  = data_word[TYPE_BITS-1:0];
    twr.en      = in_fire && (op == OP_WR_SLOT);
    twr.slot    = table_slot;
    twr.data    = data_word;
  end

  bas_terrain u_terrain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .cfg   (gcfg),
    .stat  (mstat)
  );

  bas_tile u_tile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (twr),
    .mstat     (mstat),
    .res_ready (load),
    .res       (tres)
  );

  // Output register takes a result when empty or being drained
  assign load = tres.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (sreq.qry_en) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {1'b0, (tres.value == '0), tres.slot, tres.value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
